@@ hw/rtl/egcd_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge-directed demosaic package
// Shared widths, types, register indexes and the arithmetic helpers used by
// the demosaic datapath and its line memories.
// ----------------------------------------------------------------------------
package egcd_pkg;

  localparam int SAMPLE_BITS    = 12;
  localparam int MAX_WIDTH      = 4096;
  localparam int COL_BITS       = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS     = COL_BITS + 1;
  localparam int HEIGHT_BITS    = 16;
  localparam int RING_ROWS      = 8;
  localparam int SLOT_BITS      = $clog2(RING_ROWS);
  localparam int PIX_BITS       = SAMPLE_BITS + 3;
  localparam int CNT_BITS       = WIDTH_BITS + 1;
  localparam int DIFF_BITS      = PIX_BITS + 2;
  localparam int SUM_BITS       = DIFF_BITS + 2;
  localparam int MIN_DIM        = 5;
  localparam int CFG_BITS       = 16;
  localparam int CFG_INDEX_BITS = 3;

  typedef logic [SAMPLE_BITS-1:0]       sample_t;
  typedef logic [PIX_BITS-1:0]          pix_t;
  typedef logic [COL_BITS-1:0]          col_t;
  typedef logic [WIDTH_BITS-1:0]        width_t;
  typedef logic [HEIGHT_BITS-1:0]       height_t;
  typedef logic [SLOT_BITS-1:0]         slot_t;
  typedef logic [CNT_BITS-1:0]          cnt_t;
  typedef logic signed [DIFF_BITS-1:0]  diff_t;
  typedef logic signed [SUM_BITS-1:0]   sum_t;

  localparam pix_t OUT_MAX = PIX_BITS'(((1 << SAMPLE_BITS) - 1) * 8);

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    CFG_FRAME_WIDTH    = 3'd0,
    CFG_FRAME_HEIGHT   = 3'd1,
    CFG_GREEN_PHASE    = 3'd2,
    CFG_RED_COL_PHASE  = 3'd3,
    CFG_RED_ROW_PHASE  = 3'd4,
    CFG_BLUE_COL_PHASE = 3'd5,
    CFG_BLUE_ROW_PHASE = 3'd6
  } cfg_reg_t;

  // Green at a red or blue site: mean of the flatter neighbor pair.
  // Ties go to the vertical pair.
  function automatic pix_t green_interp(input sample_t l, input sample_t r,
                                        input sample_t u, input sample_t d);
    sample_t                dh;
    sample_t                dv;
    logic [SAMPLE_BITS:0]   s;
    dh = (l > r) ? (l - r) : (r - l);
    dv = (u > d) ? (u - d) : (d - u);
    s  = (dh < dv) ? ({1'b0, l} + {1'b0, r}) : ({1'b0, u} + {1'b0, d});
    return {s, 2'b00};
  endfunction

  // Color difference averaged over the same-color neighbors, plus the
  // center green, clamped to the output range. The sums are always
  // multiples of four, so the shifts are exact.
  function automatic pix_t chroma_value(input logic cx, input logic cy,
                                        input diff_t dc, input diff_t dl,
                                        input diff_t dr, input diff_t du,
                                        input diff_t dd, input diff_t dul,
                                        input diff_t dur, input diff_t ddl,
                                        input diff_t ddr, input pix_t gc);
    sum_t acc;
    sum_t v;
    if (!cx && !cy) begin
      acc = sum_t'(dc);
    end else if (cx && cy) begin
      acc = (sum_t'(dul) + sum_t'(dur) + sum_t'(ddl) + sum_t'(ddr)) >>> 2;
    end else if (!cx) begin
      acc = (sum_t'(du) + sum_t'(dd)) >>> 1;
    end else begin
      acc = (sum_t'(dl) + sum_t'(dr)) >>> 1;
    end
    v = acc + sum_t'(gc);
    if (v < 0) begin
      return '0;
    end else if (v > sum_t'(OUT_MAX)) begin
      return OUT_MAX;
    end
    return v[PIX_BITS-1:0];
  endfunction

endpackage

@@ hw/rtl/egcd_line_ram.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Raw line memory
// One row of raw samples: one write port and one registered read port.
// A read at the address being written returns the old contents.
// ----------------------------------------------------------------------------
module egcd_line_ram (
  input  logic              clk,
  input  logic              write,
  input  egcd_pkg::col_t    write_addr,
  input  egcd_pkg::sample_t write_data,
  input  logic              read,
  input  egcd_pkg::col_t    read_addr,
  output egcd_pkg::sample_t read_data
);
  import egcd_pkg::*;

  sample_t mem [MAX_WIDTH];

  // Single write port and registered read port.
  always_ff @(posedge clk) begin
    if (write) begin
      mem[write_addr] <= write_data;
    end
    if (read) begin
      read_data <= mem[read_addr];
    end
  end

endmodule

@@ hw/rtl/edge_green_color_difference_demosaic_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge-directed Bayer demosaic
// Raw Bayer samples in, RGB pixels in units of 1/8 sample step out.
// ----------------------------------------------------------------------------
// The block takes one raw sample per clock and gives one RGB pixel per
// clock in steady state while the output is not stalled, two rows and two
// pixels behind the input, through the read, window, green and output
// registers. Eight line memories, one read and one write a cycle each,
// hold the ring of recent rows, and a 5x5 window fed by one column read
// per pixel carries the neighborhood, so the memories do not limit the
// rate below one pixel per clock. When a frame starts after the previous
// one was flushed, the block holds off its first sample until its read
// and window stages have drained, for as long as an output stall holds
// them. After the last sample of a frame, send pad requests to flush the
// remaining two rows and two pixels; pads are otherwise ignored.
// ----------------------------------------------------------------------------
module edge_green_color_difference_demosaic_top (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    cfg_write,
  input  logic [egcd_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
  input  logic [egcd_pkg::CFG_BITS-1:0]           cfg_data,
  input  logic                                    sample_valid,
  output logic                                    sample_stall,
  input  egcd_pkg::sample_t                       sample,
  input  logic                                    pad,
  output logic                                    pixel_valid,
  input  logic                                    pixel_stall,
  output egcd_pkg::pix_t                          red,
  output egcd_pkg::pix_t                          green,
  output egcd_pkg::pix_t                          blue,
  output logic                                    frame_end
);
  import egcd_pkg::*;

  typedef struct packed {
    logic gb;
    logic cb;
    logic gpar;
    logic rcx;
    logic rcy;
    logic bcx;
    logic bcy;
    logic fend;
  } side_t;

  typedef logic [HEIGHT_BITS:0] row_ext_t;

  // Configuration registers.
  width_t  frame_width;
  height_t frame_height;
  logic    green_phase;
  logic    red_col_phase;
  logic    red_row_phase;
  logic    blue_col_phase;
  logic    blue_row_phase;

  // Position state.
  col_t    in_col;
  height_t in_row;
  slot_t   in_slot;
  col_t    out_col;
  height_t out_row;
  slot_t   out_slot;
  cnt_t    count;

  // Pipeline state.
  logic                 vm, vw, vg, vo;
  logic                 ready_m, ready_w, ready_g, ready_o;
  slot_t                m_slot;
  side_t                m_side;
  logic [RING_ROWS-1:0] m_fwd;
  sample_t              m_fwd_data;
  sample_t              bank_q [RING_ROWS];
  sample_t              col_new [5];
  sample_t              win [5][5];
  side_t                w_side;
  pix_t                 g_gr [3][3];
  sample_t              g_raw [3][3];
  side_t                g_side;
  pix_t                 gr_calc [3][3];
  diff_t                dif [3][3];
  pix_t                 red_calc, blue_calc;

  // Combinational control.
  width_t   w_eff;
  height_t  h_eff;
  cnt_t     thr;
  logic     acc, wr, emit_pad, emit_smp, emit, snoop;
  width_t   x2, xw, lead_sum;
  logic     lead_wrap;
  col_t     lead_col;
  slot_t    lead_slot;
  row_ext_t y17, h17;
  side_t    side0;
  width_t   in_col_inc, out_col_inc;
  row_ext_t in_row_inc, out_row_inc;

  // Effective frame size, clamped to the supported range.
  always_comb begin
    if (frame_width < width_t'(MIN_DIM)) begin
      w_eff = width_t'(MIN_DIM);
    end else if (frame_width > width_t'(MAX_WIDTH)) begin
      w_eff = width_t'(MAX_WIDTH);
    end else begin
      w_eff = frame_width;
    end
    h_eff = (frame_height < height_t'(MIN_DIM)) ? height_t'(MIN_DIM) : frame_height;
    thr   = {w_eff, 1'b0} + cnt_t'(2);
  end

  // Request decode: which requests release a pixel.
  always_comb begin
    acc      = sample_valid && !sample_stall;
    wr       = acc && !pad;
    emit_pad = pad && (in_col == '0) && (in_row == '0) && (count != '0);
    emit_smp = !pad && (count >= thr);
    emit     = acc && (emit_pad || emit_smp);
    snoop    = (in_slot == out_slot) && (out_col == '0) && (in_col < col_t'(2));
  end

  // Handshake chain through the pipeline.
  always_comb begin
    ready_o      = !vo || !pixel_stall;
    ready_g      = !vg || ready_o;
    ready_w      = !vw || ready_g;
    ready_m      = !vm || ready_w;
    sample_stall = !ready_m || (snoop && (vm || vw));
  end

  // Lead column of the window and per-pixel border and phase flags.
  always_comb begin
    xw        = {1'b0, out_col};
    x2        = xw + width_t'(2);
    lead_wrap = (x2 >= w_eff);
    lead_sum  = lead_wrap ? (x2 - w_eff) : x2;
    lead_col  = lead_sum[COL_BITS-1:0];
    lead_slot = out_slot + slot_t'(lead_wrap);
    y17       = {1'b0, out_row};
    h17       = {1'b0, h_eff};
    side0.gb  = (out_col == '0) || (xw + width_t'(2) > w_eff) ||
                (out_row == '0) || (y17 + row_ext_t'(2) > h17);
    side0.cb  = (out_col < col_t'(2)) || (xw + width_t'(3) > w_eff) ||
                (out_row < height_t'(2)) || (y17 + row_ext_t'(3) > h17);
    side0.gpar = out_col[0] ^ out_row[0] ^ green_phase;
    side0.rcx  = out_col[0] ^ red_col_phase;
    side0.rcy  = out_row[0] ^ red_row_phase;
    side0.bcx  = out_col[0] ^ blue_col_phase;
    side0.bcy  = out_row[0] ^ blue_row_phase;
    side0.fend = (xw + width_t'(1) == w_eff) && (y17 + row_ext_t'(1) == h17);
    in_col_inc  = {1'b0, in_col} + width_t'(1);
    out_col_inc = {1'b0, out_col} + width_t'(1);
    in_row_inc  = {1'b0, in_row} + row_ext_t'(1);
    out_row_inc = {1'b0, out_row} + row_ext_t'(1);
  end

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width    <= width_t'(640);
      frame_height   <= height_t'(480);
      green_phase    <= 1'b0;
      red_col_phase  <= 1'b1;
      red_row_phase  <= 1'b0;
      blue_col_phase <= 1'b0;
      blue_row_phase <= 1'b1;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        CFG_FRAME_WIDTH:    frame_width    <= cfg_data[WIDTH_BITS-1:0];
        CFG_FRAME_HEIGHT:   frame_height   <= cfg_data[HEIGHT_BITS-1:0];
        CFG_GREEN_PHASE:    green_phase    <= cfg_data[0];
        CFG_RED_COL_PHASE:  red_col_phase  <= cfg_data[0];
        CFG_RED_ROW_PHASE:  red_row_phase  <= cfg_data[0];
        CFG_BLUE_COL_PHASE: blue_col_phase <= cfg_data[0];
        CFG_BLUE_ROW_PHASE: blue_row_phase <= cfg_data[0];
        default: begin
        end
      endcase
    end
  end

  // Input and output raster positions and the pending count.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_col   <= '0;
      in_row   <= '0;
      in_slot  <= '0;
      out_col  <= '0;
      out_row  <= '0;
      out_slot <= '0;
      count    <= '0;
    end else begin
      if (wr) begin
        if (in_col_inc >= w_eff) begin
          in_col  <= '0;
          in_slot <= in_slot + slot_t'(1);
          in_row  <= (in_row_inc >= h17) ? '0 : in_row_inc[HEIGHT_BITS-1:0];
        end else begin
          in_col <= in_col_inc[COL_BITS-1:0];
        end
        if (!emit_smp) begin
          count <= count + cnt_t'(1);
        end
      end else if (emit) begin
        count <= count - cnt_t'(1);
      end
      if (emit) begin
        if (out_col_inc >= w_eff) begin
          out_col  <= '0;
          out_slot <= out_slot + slot_t'(1);
          out_row  <= (out_row_inc >= h17) ? '0 : out_row_inc[HEIGHT_BITS-1:0];
        end else begin
          out_col <= out_col_inc[COL_BITS-1:0];
        end
      end
    end
  end

  // Ring of row memories: the sample goes to its row, the lead column is
  // read from all rows at once.
  for (genvar b = 0; b < RING_ROWS; b++) begin : g_bank
    egcd_line_ram u_ram (
      .clk        (clk),
      .write      (wr && (in_slot == slot_t'(b))),
      .write_addr (in_col),
      .write_data (sample),
      .read       (emit),
      .read_addr  (lead_col),
      .read_data  (bank_q[b])
    );
  end

  // Read stage: sideband and forwarding of a same-cycle write.
  always_ff @(posedge clk) begin
    if (rst) begin
      vm <= 1'b0;
    end else begin
      vm <= emit || (vm && !ready_w);
    end
    if (emit) begin
      m_slot     <= lead_slot;
      m_side     <= side0;
      m_fwd_data <= sample;
      for (int b = 0; b < RING_ROWS; b++) begin
        m_fwd[b] <= wr && (in_slot == slot_t'(b)) && (in_col == lead_col);
      end
    end
  end

  // New window column, rows two above to two below.
  always_comb begin
    for (int r = 0; r < 5; r++) begin
      col_new[r] = m_fwd[slot_t'(m_slot + slot_t'(r + RING_ROWS - 2))] ? m_fwd_data :
                   bank_q[slot_t'(m_slot + slot_t'(r + RING_ROWS - 2))];
    end
  end

  // Window stage: shift in the lead column. Samples of the first two
  // columns of a frame go straight in, as they arrive after their fetch.
  always_ff @(posedge clk) begin
    if (rst) begin
      vw <= 1'b0;
    end else begin
      vw <= (vm && ready_w) || (vw && !ready_g);
    end
    if (vm && ready_w) begin
      w_side <= m_side;
      for (int r = 0; r < 5; r++) begin
        for (int c = 0; c < 4; c++) begin
          win[r][c] <= win[r][c + 1];
        end
        win[r][4] <= col_new[r];
      end
    end else if (wr && snoop) begin
      if (in_col[0]) begin
        win[2][4] <= sample;
      end else begin
        win[2][3] <= sample;
      end
    end
  end

  // Green at the center and its eight neighbors.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        logic isg;
        if (i == 1 && j == 1) begin
          isg = w_side.gb || !w_side.gpar;
        end else if (((i + j) % 2) == 1) begin
          isg = w_side.gpar;
        end else begin
          isg = !w_side.gpar;
        end
        gr_calc[i][j] = isg ? {win[i + 1][j + 1], 3'b000} :
                        green_interp(win[i + 1][j], win[i + 1][j + 2],
                                     win[i][j + 1], win[i + 2][j + 1]);
      end
    end
  end

  // Green stage registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      vg <= 1'b0;
    end else begin
      vg <= (vw && ready_g) || (vg && !ready_o);
    end
    if (vw && ready_g) begin
      g_side <= w_side;
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          g_gr[i][j]  <= gr_calc[i][j];
          g_raw[i][j] <= win[i + 1][j + 1];
        end
      end
    end
  end

  // Color differences and red and blue.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        dif[i][j] = diff_t'({g_raw[i][j], 3'b000}) - diff_t'(g_gr[i][j]);
      end
    end
    red_calc  = chroma_value(g_side.rcx, g_side.rcy, dif[1][1], dif[1][0], dif[1][2],
                             dif[0][1], dif[2][1], dif[0][0], dif[0][2], dif[2][0],
                             dif[2][2], g_gr[1][1]);
    blue_calc = chroma_value(g_side.bcx, g_side.bcy, dif[1][1], dif[1][0], dif[1][2],
                             dif[0][1], dif[2][1], dif[0][0], dif[0][2], dif[2][0],
                             dif[2][2], g_gr[1][1]);
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      vo <= 1'b0;
    end else begin
      vo <= (vg && ready_o) || (vo && pixel_stall);
    end
    if (vg && ready_o) begin
      red       <= g_side.cb ? {g_raw[1][1], 3'b000} : red_calc;
      blue      <= g_side.cb ? {g_raw[1][1], 3'b000} : blue_calc;
      green     <= g_gr[1][1];
      frame_end <= g_side.fend;
    end
  end

  assign pixel_valid = vo;

endmodule

@@ bench/edge_green_color_difference_demosaic_top_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Edge-directed demosaic testbench
// Streams Bayer frames of many sizes and phase settings through the block,
// with random gaps and back-pressure. It predicts each RGB pixel from its own
// copy of the row ring and compares every delivered pixel field by field.
// ----------------------------------------------------------------------------
module edge_green_color_difference_demosaic_top_tb;
  import egcd_pkg::*;

  localparam int IDLE_PCT     = 13;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 16;
  localparam int RANDOM_ITEMS = 1000;

  typedef struct packed {
    sample_t value;
    logic    pad;
  } request_t;

  typedef struct packed {
    pix_t red;
    pix_t green;
    pix_t blue;
    logic frame_end;
  } pixel_t;

  logic                      clk = 1'b0;
  logic                      rst = 1'b1;
  logic                      cfg_write = 1'b0;
  logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
  logic [CFG_BITS-1:0]       cfg_data = '0;
  logic                      sample_valid = 1'b0;
  logic                      sample_stall;
  sample_t                   sample = '0;
  logic                      pad = 1'b0;
  logic                      pixel_valid;
  logic                      pixel_stall = 1'b0;
  pix_t                      red;
  pix_t                      green;
  pix_t                      blue;
  logic                      frame_end;

  request_t    pending_requests[$];
  pixel_t      expected_pixels[$];
  int          failures = 0;
  int          quiet_cycles = 0;
  bit          calm = 1'b0;

  // Shadow of the row ring and the block's registers and counters.
  bit [SAMPLE_BITS-1:0] mosaic_rows[RING_ROWS][MAX_WIDTH];
  int unsigned width_reg = 640;
  int unsigned height_reg = 480;
  bit          green_ph = 1'b0;
  bit          red_cph = 1'b1;
  bit          red_rph = 1'b0;
  bit          blue_cph = 1'b0;
  bit          blue_rph = 1'b1;
  int unsigned in_col = 0, in_row = 0, in_slot = 0;
  int unsigned out_col = 0, out_row = 0, out_slot = 0;
  int unsigned backlog = 0;

  edge_green_color_difference_demosaic_top uut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .sample_valid (sample_valid),
    .sample_stall (sample_stall),
    .sample       (sample),
    .pad          (pad),
    .pixel_valid  (pixel_valid),
    .pixel_stall  (pixel_stall),
    .red          (red),
    .green        (green),
    .blue         (blue),
    .frame_end    (frame_end)
  );

  always #2 clk = ~clk;

  function automatic int clamp_width(int unsigned w);
    if (w < MIN_DIM) return MIN_DIM;
    if (w > MAX_WIDTH) return MAX_WIDTH;
    return int'(w);
  endfunction

  function automatic int clamp_height(int unsigned h);
    return (h < MIN_DIM) ? MIN_DIM : int'(h);
  endfunction

  function automatic bit idle_roll();
    return !calm && ($urandom_range(99) < IDLE_PCT);
  endfunction

  // Raw sample at column col, dy rows away from the output row.
  function automatic int mosaic_at(int col, int dy);
    int s;
    if (col < 0 || col >= MAX_WIDTH) return 0;
    s = (int'(out_slot) + RING_ROWS + dy) & (RING_ROWS - 1);
    return int'(mosaic_rows[s][col]);
  endfunction

  function automatic int abs_gap(int a, int b);
    return (a > b) ? a - b : b - a;
  endfunction

  // Green: flatter neighbor pair at non-green sites, raw elsewhere.
  function automatic int green_estimate(int px, int dy, int y, int w, int h);
    int py, c, l, r, u, d;
    py = y + dy;
    c  = mosaic_at(px, dy);
    if (px < 1 || px > w - 2 || py < 1 || py > h - 2) return c * 8;
    if (((px + py + int'(green_ph)) % 2) == 0) return c * 8;
    l = mosaic_at(px - 1, dy);
    r = mosaic_at(px + 1, dy);
    u = mosaic_at(px, dy - 1);
    d = mosaic_at(px, dy + 1);
    if (abs_gap(l, r) < abs_gap(u, d)) return (l + r) * 4;
    return (u + d) * 4;
  endfunction

  function automatic int color_gap(int px, int dy, int y, int w, int h);
    return mosaic_at(px, dy) * 8 - green_estimate(px, dy, y, w, h);
  endfunction

  // Red or blue: mean color difference of same-color neighbors plus green.
  function automatic int chroma_estimate(int x, int y, int w, int h, bit cp, bit rp);
    bit cx, cy;
    int s, v;
    if (x < 2 || x > w - 3 || y < 2 || y > h - 3) return mosaic_at(x, 0) * 8;
    cx = 1'((x + int'(cp)) & 1);
    cy = 1'((y + int'(rp)) & 1);
    if (!cx && !cy) begin
      s = color_gap(x, 0, y, w, h);
    end else if (cx && cy) begin
      s = (color_gap(x - 1, -1, y, w, h) + color_gap(x + 1, -1, y, w, h) +
           color_gap(x - 1, 1, y, w, h) + color_gap(x + 1, 1, y, w, h)) / 4;
    end else if (!cx) begin
      s = (color_gap(x, -1, y, w, h) + color_gap(x, 1, y, w, h)) / 2;
    end else begin
      s = (color_gap(x - 1, 0, y, w, h) + color_gap(x + 1, 0, y, w, h)) / 2;
    end
    v = s + green_estimate(x, 0, y, w, h);
    if (v < 0) v = 0;
    if (v > int'(OUT_MAX)) v = int'(OUT_MAX);
    return v;
  endfunction

  // Queue the pixel at the output position and advance it.
  function automatic void release_pixel(int w, int h);
    pixel_t p;
    int     x, y;
    x = int'(out_col);
    y = int'(out_row);
    p.red       = pix_t'(chroma_estimate(x, y, w, h, red_cph, red_rph));
    p.green     = pix_t'(green_estimate(x, 0, y, w, h));
    p.blue      = pix_t'(chroma_estimate(x, y, w, h, blue_cph, blue_rph));
    p.frame_end = (x == w - 1) && (y == h - 1);
    expected_pixels.push_back(p);
    out_col++;
    if (out_col >= w) begin
      out_col  = 0;
      out_slot = (out_slot + 1) % RING_ROWS;
      out_row++;
      if (out_row >= h) out_row = 0;
    end
    backlog--;
  endfunction

  // Apply one accepted request to the shadow state.
  function automatic void predict_request(request_t rq);
    int w, h;
    w = clamp_width(width_reg);
    h = clamp_height(height_reg);
    if (rq.pad) begin
      if (in_col == 0 && in_row == 0 && backlog > 0) release_pixel(w, h);
      return;
    end
    mosaic_rows[in_slot][in_col] = rq.value;
    in_col++;
    if (in_col >= w) begin
      in_col  = 0;
      in_slot = (in_slot + 1) % RING_ROWS;
      in_row++;
      if (in_row >= h) in_row = 0;
    end
    backlog++;
    if (backlog > 2 * w + 2) release_pixel(w, h);
  endfunction

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t ns: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
      failures++;
    end
  endfunction

  // Sample driver: takes the next request from the pending queue.
  always @(posedge clk) begin : drive_samples
    request_t rq;
    if (rst) begin
      sample_valid <= 1'b0;
    end else if (!sample_valid || !sample_stall) begin
      if (sample_valid) predict_request('{value: sample, pad: pad});
      if (pending_requests.size() > 0 && !idle_roll()) begin
        rq = pending_requests.pop_front();
        sample_valid <= 1'b1;
        sample       <= rq.value;
        pad          <= rq.pad;
      end else begin
        sample_valid <= 1'b0;
      end
    end
  end

  // Pixel monitor with random back-pressure.
  always @(posedge clk) begin : collect_pixels
    pixel_t want;
    if (rst) begin
      pixel_stall <= 1'b0;
    end else begin
      if (pixel_valid && !pixel_stall) begin
        if (expected_pixels.size() == 0) begin
          $display("%0t ns: unexpected pixel, expected none, actual r=%0d g=%0d b=%0d end=%0b",
                   $time, red, green, blue, frame_end);
          failures++;
        end else begin
          want = expected_pixels.pop_front();
          check_field("red", want.red, red);
          check_field("green", want.green, green);
          check_field("blue", want.blue, blue);
          check_field("frame_end", want.frame_end, frame_end);
        end
      end
      pixel_stall <= idle_roll();
    end
  end

  // Watchdog on cycles with no accepted request on either side.
  always @(posedge clk) begin
    if ((sample_valid && !sample_stall) || (pixel_valid && !pixel_stall)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout after %0d quiet cycles at %0t ns", quiet_cycles, $time);
        $display("** edge_green_color_difference_demosaic_top: FAILED **");
        $finish;
      end
    end
  end

  task automatic write_reg(cfg_reg_t idx, int unsigned val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_BITS'(val);
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      CFG_FRAME_WIDTH:    width_reg  = val & 16'h1FFF;
      CFG_FRAME_HEIGHT:   height_reg = val & 16'hFFFF;
      CFG_GREEN_PHASE:    green_ph   = val[0];
      CFG_RED_COL_PHASE:  red_cph    = val[0];
      CFG_RED_ROW_PHASE:  red_rph    = val[0];
      CFG_BLUE_COL_PHASE: blue_cph   = val[0];
      CFG_BLUE_ROW_PHASE: blue_rph   = val[0];
      default: ;
    endcase
  endtask

  task automatic set_frame(int unsigned w, int unsigned h, bit gp, bit rcp, bit rrp,
                           bit bcp, bit brp);
    write_reg(CFG_FRAME_WIDTH, w);
    write_reg(CFG_FRAME_HEIGHT, h);
    write_reg(CFG_GREEN_PHASE, gp);
    write_reg(CFG_RED_COL_PHASE, rcp);
    write_reg(CFG_RED_ROW_PHASE, rrp);
    write_reg(CFG_BLUE_COL_PHASE, bcp);
    write_reg(CFG_BLUE_ROW_PHASE, brp);
    @(negedge clk);
  endtask

  // One frame of samples; style picks noise, smooth ramps or hard extremes.
  // Stray pads are sprinkled in; mid-frame they are ignored.
  task automatic queue_frame(int w, int h, int style);
    int      base;
    sample_t v;
    base = $urandom_range(3000);
    for (int i = 0; i < w * h; i++) begin
      case (style)
        0: v = sample_t'($urandom);
        1: v = sample_t'(base + (i % w) * 13 + (i / w) * 29 + $urandom_range(7));
        default: v = $urandom_range(1) ? '1 : '0;
      endcase
      pending_requests.push_back('{value: v, pad: 1'b0});
      if ($urandom_range(99) < 3)
        pending_requests.push_back('{value: sample_t'($urandom), pad: 1'b1});
    end
  endtask

  task automatic queue_flush(int w);
    int n;
    n = 2 * w + 2 + $urandom_range(3);
    for (int i = 0; i < n; i++)
      pending_requests.push_back('{value: sample_t'($urandom), pad: 1'b1});
  endtask

  task automatic wait_idle();
    while (pending_requests.size() > 0 || sample_valid || expected_pixels.size() > 0)
      @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic run_phase(int unsigned w, int unsigned h, int frames, int style);
    for (int f = 0; f < frames; f++)
      queue_frame(clamp_width(w), clamp_height(h), style);
    queue_flush(clamp_width(w));
    wait_idle();
  endtask

  initial begin : stimulus
    sample_t directed[25];
    int      sent;
    int unsigned w, h;
    int      frames;
    directed = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0,
                 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd4095,
                 12'd100, 12'd200, 12'd300, 12'd200, 12'd100,
                 12'd4095, 12'd4095, 12'd0, 12'd4095, 12'd4095,
                 12'd0, 12'd0, 12'd4095, 12'd0, 12'd0};
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // Directed 5x5 frame: extremes, flat ties and saturation, then flush.
    set_frame(5, 5, 0, 1, 0, 0, 1);
    foreach (directed[i]) pending_requests.push_back('{value: directed[i], pad: 1'b0});
    pending_requests.push_back('{value: '1, pad: 1'b1});
    queue_flush(5);
    wait_idle();

    // Random small frames with random phases; some sizes out of range.
    sent = 0;
    for (int p = 0; sent < RANDOM_ITEMS; p++) begin
      w = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(5, 12);
      h = ($urandom_range(9) == 0) ? $urandom_range(4) : $urandom_range(5, 9);
      frames = $urandom_range(1, 3);
      calm = (p == 4);
      set_frame(w, h, $urandom_range(1), $urandom_range(1), $urandom_range(1),
                $urandom_range(1), $urandom_range(1));
      run_phase(w, h, frames, (p % 5 == 0) ? 2 : $urandom_range(1));
      sent += frames * clamp_width(w) * clamp_height(h);
    end
    calm = 1'b0;

    // Smallest size codes, clamped up to the minimum frame.
    set_frame(0, 0, 1, 1, 1, 1, 1);
    run_phase(0, 0, 2, 2);

    if (failures == 0) begin
      $display("** edge_green_color_difference_demosaic_top: PASSED **");
    end else begin
      $display("** edge_green_color_difference_demosaic_top: FAILED **");
    end
    $finish;
  end

endmodule
